/* design/lgu_pkg.sv */
// Lenia grid update package: operation and register codes, command/status
// structs, reset values and the exp(-x) table builder. No dependencies.
package lgu_pkg;

  localparam int OP_W    = 2;
  localparam int INDEX_W = 12;
  localparam int VALUE_W = 16;
  localparam int CFG_W   = 24;
  localparam int CFG_AW  = 3;

  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

  typedef enum logic [OP_W-1:0] {
    OP_WR_CELL = 2'd0,
    OP_WR_KERN = 2'd1,
    OP_GEN     = 2'd2,
    OP_RD_CELL = 2'd3
  } op_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_GRID_WIDTH   = 3'd0,
    REG_GRID_HEIGHT  = 3'd1,
    REG_KERNEL_RAD   = 3'd2,
    REG_KERNEL_NORM  = 3'd3,
    REG_GROWTH_CTR   = 3'd4,
    REG_GROWTH_INVW  = 3'd5,
    REG_GROWTH_AMP   = 3'd6,
    REG_GROWTH_OFS   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [6:0]         grid_width;
    logic [6:0]         grid_height;
    logic [3:0]         kernel_radius;
    logic [23:0]        kernel_norm;
    logic [15:0]        growth_center;
    logic [23:0]        growth_inv_width;
    logic signed [15:0] growth_amp_dt;
    logic signed [15:0] growth_offset_dt;
  } cfg_t;

  localparam logic [6:0]  RST_GRID_WIDTH  = 7'd64;
  localparam logic [6:0]  RST_GRID_HEIGHT = 7'd64;
  localparam logic [3:0]  RST_KERNEL_RAD  = 4'd13;
  localparam logic [15:0] RST_GROWTH_CTR  = 16'd4915;

  typedef struct packed {
    logic bank_sel;
    logic gen_start;
    logic mod_step;
    logic cell_init;
    logic tap;
    logic ctr_rd;
    logic norm;
    logic sq;
    logic xlo;
    logic xhi;
    logic xsum;
    logic expv;
    logic amp;
    logic wb;
    logic wr_cell;
    logic wr_kern;
    logic rd_cell;
    logic out_load;
    logic out_zero;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic last_tap;
    logic last_cell;
    logic idx_cell_ok;
  } status_t;

  // entry k = exp(-k/16) in Q1.15, built by repeated Q32 multiplication
  function automatic logic [15:0] exp_entry(input int k);
    logic [95:0] p;
    logic [95:0] e;
    p = 96'd1 << 32;
    for (int j = 0; j < k; j++) begin
      p = ((p * {32'd0, EXP_STEP_Q32}) + (96'd1 << 31)) >> 32;
    end
    e = (p + 96'd65536) >> 17;
    return e[15:0];
  endfunction

endpackage

/* design/lgu_in_if.sv */
// Input channel of the Lenia grid update unit: op, index and value words.
// Depends on lgu_pkg.
interface lgu_in_if;
  logic                        valid;
  logic                        ready;
  logic [lgu_pkg::OP_W-1:0]    op;
  logic [lgu_pkg::INDEX_W-1:0] index;
  logic [lgu_pkg::VALUE_W-1:0] value;
  modport source(output valid, op, index, value, input ready);
  modport sink(input valid, op, index, value, output ready);
endinterface

/* design/lgu_out_if.sv */
// Result channel of the Lenia grid update unit: one cell_value word per item.
// Depends on lgu_pkg.
interface lgu_out_if;
  logic                        valid;
  logic                        ready;
  logic [lgu_pkg::VALUE_W-1:0] cell_value;
  modport source(output valid, cell_value, input ready);
  modport sink(input valid, cell_value, output ready);
endinterface

/* design/lgu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lgu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* design/lgu_ctrl.sv */
// Lenia grid update controller: handshake, result staging, bank select and
// the generation sequencer. Depends on lgu_pkg.
module lgu_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [lgu_pkg::OP_W-1:0] in_op,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  lgu_pkg::status_t         status,
  output lgu_pkg::cmd_t            cmd
);
  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_MODW  = 15'b000000000000010,
    ST_INIT  = 15'b000000000000100,
    ST_TAP   = 15'b000000000001000,
    ST_CTR   = 15'b000000000010000,
    ST_DRAIN = 15'b000000000100000,
    ST_NORM  = 15'b000000001000000,
    ST_SQ    = 15'b000000010000000,
    ST_XLO   = 15'b000000100000000,
    ST_XHI   = 15'b000001000000000,
    ST_XSUM  = 15'b000010000000000,
    ST_EXPV  = 15'b000100000000000,
    ST_AMP   = 15'b001000000000000,
    ST_WB    = 15'b010000000000000,
    ST_FIN   = 15'b100000000000000
  } state_t;

  state_t state, state_next;
  logic   p1_valid, p1_zero, bank_sel;
  logic   p1_move, accept;
  lgu_pkg::op_e op;

  assign op       = lgu_pkg::op_e'(in_op);
  assign p1_move  = p1_valid && (!out_valid || out_ready);
  assign in_ready = (state == ST_IDLE) && (!p1_valid || p1_move);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.bank_sel  = bank_sel;
    cmd.gen_start = accept && (op == lgu_pkg::OP_GEN);
    cmd.wr_cell   = accept && (op == lgu_pkg::OP_WR_CELL);
    cmd.wr_kern   = accept && (op == lgu_pkg::OP_WR_KERN);
    cmd.rd_cell   = accept && (op == lgu_pkg::OP_RD_CELL);
    cmd.out_load  = p1_move;
    cmd.out_zero  = p1_zero;
    cmd.mod_step  = (state == ST_MODW) && !status.mod_done;
    cmd.cell_init = (state == ST_INIT);
    cmd.tap       = (state == ST_TAP);
    cmd.ctr_rd    = (state == ST_CTR);
    cmd.norm      = (state == ST_NORM);
    cmd.sq        = (state == ST_SQ);
    cmd.xlo       = (state == ST_XLO);
    cmd.xhi       = (state == ST_XHI);
    cmd.xsum      = (state == ST_XSUM);
    cmd.expv      = (state == ST_EXPV);
    cmd.amp       = (state == ST_AMP);
    cmd.wb        = (state == ST_WB);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (cmd.gen_start) state_next = ST_MODW;
      ST_MODW:  if (status.mod_done) state_next = ST_INIT;
      ST_INIT:  state_next = ST_TAP;
      ST_TAP:   if (status.last_tap) state_next = ST_CTR;
      ST_CTR:   state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_NORM;
      ST_NORM:  state_next = ST_SQ;
      ST_SQ:    state_next = ST_XLO;
      ST_XLO:   state_next = ST_XHI;
      ST_XHI:   state_next = ST_XSUM;
      ST_XSUM:  state_next = ST_EXPV;
      ST_EXPV:  state_next = ST_AMP;
      ST_AMP:   state_next = ST_WB;
      ST_WB:    state_next = status.last_cell ? ST_FIN : ST_INIT;
      ST_FIN:   if (!p1_valid) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      p1_valid  <= 1'b0;
      p1_zero   <= 1'b0;
      out_valid <= 1'b0;
      bank_sel  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (op != lgu_pkg::OP_GEN)) begin
        p1_valid <= 1'b1;
        p1_zero  <= !((op == lgu_pkg::OP_RD_CELL) && status.idx_cell_ok);
      end else if ((state == ST_FIN) && !p1_valid) begin
        p1_valid <= 1'b1;
        p1_zero  <= 1'b1;
        bank_sel <= !bank_sel;
      end else if (p1_move) begin
        p1_valid <= 1'b0;
      end
      if (p1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

/* design/lgu_dp.sv */
// Lenia grid update datapath: cell banks, kernel store, window counters,
// MAC pipeline and growth arithmetic. Depends on lgu_pkg and lgu_ram.
module lgu_dp #(
  parameter int MAX_GRID_WIDTH    = 64,
  parameter int MAX_GRID_HEIGHT   = 64,
  parameter int MAX_KERNEL_RADIUS = 15,
  parameter int EXP_TABLE_DEPTH   = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lgu_pkg::cfg_t               cfg,
  input  lgu_pkg::cmd_t               cmd,
  output lgu_pkg::status_t            status,
  input  logic [lgu_pkg::INDEX_W-1:0] in_index,
  input  logic [lgu_pkg::VALUE_W-1:0] in_value,
  output logic [lgu_pkg::VALUE_W-1:0] cell_value
);
  localparam int WW   = $clog2(MAX_GRID_WIDTH + 1);
  localparam int HW   = $clog2(MAX_GRID_HEIGHT + 1);
  localparam int CW   = $clog2(MAX_GRID_WIDTH);
  localparam int RW   = $clog2(MAX_GRID_HEIGHT);
  localparam int CD   = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
  localparam int CA   = $clog2(CD);
  localparam int RB   = $clog2(MAX_KERNEL_RADIUS + 1);
  localparam int SB   = $clog2(2 * MAX_KERNEL_RADIUS + 2);
  localparam int KD   = (2 * MAX_KERNEL_RADIUS + 2) * (2 * MAX_KERNEL_RADIUS + 2);
  localparam int KA   = $clog2(KD);
  localparam int SUMW = 32 + KA;
  localparam int UW   = SUMW - 15;
  localparam int NPW  = UW + 24;
  localparam int SQW  = (2 * UW > 54) ? 2 * UW : 54;
  localparam int XW   = 49;
  localparam int EA   = $clog2(EXP_TABLE_DEPTH);

  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [RB-1:0] r;
  logic [SB-1:0] side_m1;

  assign w = (cfg.grid_width == 7'd0) ? WW'(1) :
             ((32'(cfg.grid_width) > MAX_GRID_WIDTH) ? WW'(MAX_GRID_WIDTH) :
              WW'(cfg.grid_width));
  assign h = (cfg.grid_height == 7'd0) ? HW'(1) :
             ((32'(cfg.grid_height) > MAX_GRID_HEIGHT) ? HW'(MAX_GRID_HEIGHT) :
              HW'(cfg.grid_height));
  assign r = (32'(cfg.kernel_radius) > MAX_KERNEL_RADIUS) ? RB'(MAX_KERNEL_RADIUS) :
             RB'(cfg.kernel_radius);
  assign side_m1 = SB'(32'(r) * 2);

  logic [RB-1:0] rmw, rmh;
  logic [CW-1:0] col, cc, cc0;
  logic [RW-1:0] row, rr;
  logic [SB-1:0] dx, dy;
  logic [KA-1:0] ki;
  logic          v1, v2;
  logic [31:0]   prod;
  logic [SUMW-1:0] acc;
  logic [15:0]   ctr;
  logic [NPW-1:0] nprod;
  logic [SQW-1:0] sq;
  logic [43:0]   xlo;
  logic [42:0]   xhi;
  logic [XW-1:0] x;
  logic [15:0]   g;
  logic signed [32:0] p;

  logic [CA-1:0] idx_ca, tap_addr, cell_addr, cur_raddr;
  logic          cur_re, wr_cell_ok, wr_kern_ok;
  logic [15:0]   a_rdata, b_rdata, cur_rdata, k_rdata;
  logic [15:0]   new_cell;

  assign idx_ca    = CA'(in_index);
  assign tap_addr  = CA'(32'(rr) * 32'(w) + 32'(cc));
  assign cell_addr = CA'(32'(row) * 32'(w) + 32'(col));
  assign cur_raddr = cmd.tap ? tap_addr : (cmd.ctr_rd ? cell_addr : idx_ca);
  assign cur_re    = cmd.tap || cmd.ctr_rd || cmd.rd_cell;

  assign status.idx_cell_ok = 32'(in_index) < (32'(w) * 32'(h));
  assign status.mod_done    = (32'(rmw) < 32'(w)) && (32'(rmh) < 32'(h));
  assign status.last_tap    = (dx == side_m1) && (dy == side_m1);
  assign status.last_cell   = (32'(col) == 32'(w) - 1) && (32'(row) == 32'(h) - 1);

  assign wr_cell_ok = cmd.wr_cell && status.idx_cell_ok;
  assign wr_kern_ok = cmd.wr_kern && (32'(in_index) < KD);
  assign cur_rdata  = cmd.bank_sel ? b_rdata : a_rdata;

  lgu_ram #(.WIDTH(16), .DEPTH(CD)) u_bank_a (
    .clk  (clk),
    .we   (cmd.bank_sel ? cmd.wb : wr_cell_ok),
    .waddr(cmd.bank_sel ? cell_addr : idx_ca),
    .wdata(cmd.bank_sel ? new_cell : in_value),
    .re   (!cmd.bank_sel && cur_re),
    .raddr(cur_raddr),
    .rdata(a_rdata)
  );

  lgu_ram #(.WIDTH(16), .DEPTH(CD)) u_bank_b (
    .clk  (clk),
    .we   (cmd.bank_sel ? wr_cell_ok : cmd.wb),
    .waddr(cmd.bank_sel ? idx_ca : cell_addr),
    .wdata(cmd.bank_sel ? in_value : new_cell),
    .re   (cmd.bank_sel && cur_re),
    .raddr(cur_raddr),
    .rdata(b_rdata)
  );

  lgu_ram #(.WIDTH(16), .DEPTH(KD)) u_kernel (
    .clk  (clk),
    .we   (wr_kern_ok),
    .waddr(KA'(in_index)),
    .wdata(in_value),
    .re   (cmd.tap),
    .raddr(ki),
    .rdata(k_rdata)
  );

  logic [15:0] exp_tab [EXP_TABLE_DEPTH];
  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_exp
    assign exp_tab[k] = lgu_pkg::exp_entry(k);
  end

  // growth arithmetic
  logic [UW-1:0]   u, ad;
  logic [38:0]     d2;
  logic [EA-1:0]   ia, ib;
  logic [15:0]     ta, tb, dab;
  logic [19:0]     m;
  logic            in_rng;
  logic [15:0]     g_next;
  logic signed [21:0] delta;
  logic signed [22:0] vsum;

  assign u  = nprod[NPW-1:24];
  assign ad = (u >= UW'(cfg.growth_center)) ? (u - UW'(cfg.growth_center)) :
              (UW'(cfg.growth_center) - u);
  assign d2 = ((sq >> 54) != '0) ? {39{1'b1}} : sq[53:15];

  assign ia     = x[4 +: EA];
  assign ib     = EA'(32'(ia) + 1);
  assign in_rng = (x >> (4 + EA)) == '0;
  assign ta     = exp_tab[ia];
  assign tb     = ((32'(ia) + 1) < EXP_TABLE_DEPTH) ? exp_tab[ib] : 16'd0;
  assign dab    = ta - tb;
  assign m      = 20'(dab) * 20'(x[3:0]);
  assign g_next = in_rng ? (ta - 16'(m >> 4)) : 16'd0;

  assign delta = 22'(p >>> 12) + (22'(cfg.growth_offset_dt) <<< 3);
  assign vsum  = $signed({7'd0, ctr}) + 23'(delta);
  assign new_cell = (vsum < 23'sd0) ? 16'd0 :
                    ((vsum > 23'sd32768) ? 16'd32768 : 16'(vsum));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.tap;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_start) begin
      rmw <= r;
      rmh <= r;
      row <= '0;
      col <= '0;
    end
    if (cmd.mod_step) begin
      if (32'(rmw) >= 32'(w)) rmw <= RB'(32'(rmw) - 32'(w));
      if (32'(rmh) >= 32'(h)) rmh <= RB'(32'(rmh) - 32'(h));
    end
    if (cmd.cell_init) begin
      rr  <= (32'(row) >= 32'(rmh)) ? RW'(32'(row) - 32'(rmh)) :
             RW'(32'(row) + 32'(h) - 32'(rmh));
      cc  <= (32'(col) >= 32'(rmw)) ? CW'(32'(col) - 32'(rmw)) :
             CW'(32'(col) + 32'(w) - 32'(rmw));
      cc0 <= (32'(col) >= 32'(rmw)) ? CW'(32'(col) - 32'(rmw)) :
             CW'(32'(col) + 32'(w) - 32'(rmw));
      dx  <= '0;
      dy  <= '0;
      ki  <= '0;
      acc <= '0;
    end
    if (cmd.tap) begin
      ki <= ki + KA'(1);
      if (dx == side_m1) begin
        dx <= '0;
        dy <= dy + SB'(1);
        cc <= cc0;
        rr <= (32'(rr) == 32'(h) - 1) ? '0 : rr + RW'(1);
      end else begin
        dx <= dx + SB'(1);
        cc <= (32'(cc) == 32'(w) - 1) ? '0 : cc + CW'(1);
      end
    end
    if (v1) prod <= 32'(k_rdata) * 32'(cur_rdata);
    if (v2) acc <= acc + SUMW'(prod);
    if (cmd.norm) begin
      nprod <= NPW'(acc >> 15) * NPW'(cfg.kernel_norm);
      ctr   <= cur_rdata;
    end
    if (cmd.sq)   sq  <= SQW'(ad) * SQW'(ad);
    if (cmd.xlo)  xlo <= 44'(d2[19:0]) * 44'(cfg.growth_inv_width);
    if (cmd.xhi)  xhi <= 43'(d2[38:20]) * 43'(cfg.growth_inv_width);
    if (cmd.xsum) x   <= XW'(({21'd0, xhi} << 20) + {20'd0, xlo} >> 15);
    if (cmd.expv) g   <= g_next;
    if (cmd.amp)  p   <= 33'(cfg.growth_amp_dt) * $signed({17'd0, g});
    if (cmd.wb) begin
      if (32'(col) == 32'(w) - 1) begin
        col <= '0;
        row <= row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
    if (cmd.out_load) cell_value <= cmd.out_zero ? 16'd0 : cur_rdata;
  end
endmodule

/* design/lenia_grid_update_unit.sv */
// Lenia grid update unit, top level: configuration registers, controller and
// datapath. Depends on lgu_pkg, lgu_in_if, lgu_out_if, lgu_ctrl, lgu_dp.
//
//   channel   dir  word                         handshake
//   items     in   op, index, value             valid/ready
//   results   out  cell_value                   valid/ready
//   cfg       in   cfg_index, cfg_data          cfg_we, no wait
//
// Cell and kernel writes are made as the word is taken; a cell read result
// passes the RAM read register and the staging stage into the result register.
// A generation steps through every cell with the single multiply-accumulate
// over the window, one tap per cycle from the cell bank.
// Reset clears the handshake state and the bank select; stores hold no reset.
// A stalled result holds the next word in its stage; input stalls until free.
module lenia_grid_update_unit #(
  parameter int MAX_GRID_WIDTH    = 64,
  parameter int MAX_GRID_HEIGHT   = 64,
  parameter int MAX_KERNEL_RADIUS = 15,
  parameter int EXP_TABLE_DEPTH   = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  lgu_in_if.sink                     items,
  lgu_out_if.source                  results,
  input  logic                       cfg_we,
  input  logic [lgu_pkg::CFG_AW-1:0] cfg_index,
  input  logic [lgu_pkg::CFG_W-1:0]  cfg_data
);
  lgu_pkg::cfg_t    cfg;
  lgu_pkg::cmd_t    cmd;
  lgu_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width       <= lgu_pkg::RST_GRID_WIDTH;
      cfg.grid_height      <= lgu_pkg::RST_GRID_HEIGHT;
      cfg.kernel_radius    <= lgu_pkg::RST_KERNEL_RAD;
      cfg.kernel_norm      <= '0;
      cfg.growth_center    <= lgu_pkg::RST_GROWTH_CTR;
      cfg.growth_inv_width <= '0;
      cfg.growth_amp_dt    <= '0;
      cfg.growth_offset_dt <= '0;
    end else if (cfg_we) begin
      case (lgu_pkg::cfg_reg_e'(cfg_index))
        lgu_pkg::REG_GRID_WIDTH:  cfg.grid_width       <= cfg_data[6:0];
        lgu_pkg::REG_GRID_HEIGHT: cfg.grid_height      <= cfg_data[6:0];
        lgu_pkg::REG_KERNEL_RAD:  cfg.kernel_radius    <= cfg_data[3:0];
        lgu_pkg::REG_KERNEL_NORM: cfg.kernel_norm      <= cfg_data;
        lgu_pkg::REG_GROWTH_CTR:  cfg.growth_center    <= cfg_data[15:0];
        lgu_pkg::REG_GROWTH_INVW: cfg.growth_inv_width <= cfg_data;
        lgu_pkg::REG_GROWTH_AMP:  cfg.growth_amp_dt    <= cfg_data[15:0];
        lgu_pkg::REG_GROWTH_OFS:  cfg.growth_offset_dt <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  lgu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .in_op    (items.op),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lgu_dp #(
    .MAX_GRID_WIDTH   (MAX_GRID_WIDTH),
    .MAX_GRID_HEIGHT  (MAX_GRID_HEIGHT),
    .MAX_KERNEL_RADIUS(MAX_KERNEL_RADIUS),
    .EXP_TABLE_DEPTH  (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .in_index  (items.index),
    .in_value  (items.value),
    .cell_value(results.cell_value)
  );
endmodule
